// ===== rtl/indexed_binary_heap_queue_defines.svh =====
// Assertion macros shared by the heap queue modules.
`ifndef INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define IBHQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define IBHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ibhq_pkg.sv =====
// Shared types and codes of the indexed binary heap queue.
package ibhq_pkg;

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_UPDATE = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_PEEK   = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_FULL       = 2'd2,
		ST_NOT_QUEUED = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLR_STEP,
		DP_LOAD,
		DP_SET_STAT,
		DP_CHK_H,
		DP_INS_SETUP,
		DP_UPD_SETUP,
		DP_UP_RD,
		DP_UP_COST,
		DP_UP_MOVE,
		DP_FINAL_WR,
		DP_TOP_RD,
		DP_TOP_COST,
		DP_TOP_SAVE,
		DP_LAST_RD,
		DP_LAST_COST,
		DP_LAST_SAVE,
		DP_DEL_SETUP,
		DP_DN_RD,
		DP_DN_COST,
		DP_DN_MOVE,
		DP_DEC_FILL,
		DP_ZERO_FILL,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t stat;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  id_bad;
		logic  queued;
		logic  full;
		logic  empty;
		logic  fill_one;
		logic  last_is_id;
		logic  at_root;
		logic  leaf;
		logic  up_go;
		logic  dn_go;
		logic  del_down;
		logic  clr_last;
	} dp_stat_t;

endpackage

// ===== rtl/indexed_binary_heap_queue.sv =====
// Top level of the indexed binary heap priority queue.
// Usage:
// Operations arrive on the s_axis channel, one item per operation, and each yields
// exactly one result item on the m_axis channel, in order.
// The one-bit cfg channel sets min-first (0) or max-first (1) order; cfg_ready is
// always high and the register should only be written while no operation is pending.
// Insert and update sift the new cost up the heap and remove sifts down from the root;
// delete moves the last element into the freed slot and sifts it up or down. The sift
// loop reads the heap memory and then the cost memory once per level.
// One operation is in flight at a time; the next is accepted in the cycle after the
// result reaches the output register.
// If m_axis_tready stays low, the result is held and the block stops after the
// following operation until the register is free.
// After reset the block clears the per-element record memory with s_axis_tready
// low; the heap starts empty in min-first order.
module indexed_binary_heap_queue import ibhq_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int COST_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // mode[2:0], element_id[12:3], cost_value[44:13]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // top_element[9:0], top_cost[41:10], status[43:42],
	                                   // queued_count[54:44]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	dp_cmd_t     cmd;
	dp_stat_t    st;
	logic [9:0]  top_element;
	logic [31:0] top_cost;
	logic [1:0]  status;
	logic [10:0] queued_count;

	assign cfg_ready = 1'b1;

	ibhq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd),
		.st      (st)
	);

	ibhq_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.COST_BITS    (COST_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mode      (s_axis_tdata[2:0]),
		.in_id        (s_axis_tdata[12:3]),
		.in_cost      (signed'(s_axis_tdata[44:13])),
		.cfg_we       (cfg_valid),
		.cfg_bit      (cfg_data),
		.cmd          (cmd),
		.st           (st),
		.top_element  (top_element),
		.top_cost     (top_cost),
		.status       (status),
		.queued_count (queued_count)
	);

	assign m_axis_tdata = {1'b0, queued_count, status, top_cost, top_element};

endmodule

// ===== rtl/ibhq_ctrl.sv =====
// Sequencer of the heap queue: walks each operation through the datapath.
`include "indexed_binary_heap_queue_defines.svh"

module ibhq_ctrl import ibhq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	output logic     s_ready,
	output logic     m_valid,
	input  logic     m_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t st
);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISP, S_CHK1, S_CHK2,
		S_UP0, S_UP1, S_UP2, S_FIN,
		S_TOP1, S_TOP2, S_REM0, S_LAST1, S_LAST2,
		S_DEL1, S_DEL2, S_DN0, S_DN1, S_DN2, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   emit;

	assign s_ready = (state_q == S_IDLE);
	assign m_valid = out_valid_q;
	assign emit    = (state_q == S_DONE) && (!out_valid_q || m_ready);

	always_comb begin
		state_d   = state_q;
		cmd.op    = DP_NOP;
		cmd.stat  = ST_OK;
		case (state_q)
			S_INIT: begin
				cmd.op = DP_CLR_STEP;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (st.mode inside {MODE_INSERT, MODE_UPDATE, MODE_DELETE}) begin
					if (st.id_bad) begin
						cmd.op   = DP_SET_STAT;
						cmd.stat = ST_NOT_QUEUED;
						state_d  = S_DONE;
					end else begin
						state_d = S_CHK1;
					end
				end else if (st.mode inside {MODE_REMOVE, MODE_PEEK}) begin
					if (st.empty) begin
						cmd.op   = DP_SET_STAT;
						cmd.stat = ST_EMPTY;
						state_d  = S_DONE;
					end else begin
						cmd.op  = DP_TOP_RD;
						state_d = S_TOP1;
					end
				end else if (st.mode == MODE_CLEAR) begin
					cmd.op  = DP_ZERO_FILL;
					state_d = S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CHK1: begin
				cmd.op  = DP_CHK_H;
				state_d = S_CHK2;
			end
			S_CHK2: begin
				if (st.mode == MODE_DELETE) begin
					if (st.queued) begin
						cmd.op  = DP_LAST_RD;
						state_d = S_DEL1;
					end else begin
						cmd.op   = DP_SET_STAT;
						cmd.stat = ST_NOT_QUEUED;
						state_d  = S_DONE;
					end
				end else if (st.queued) begin
					cmd.op  = DP_UPD_SETUP;
					state_d = S_UP0;
				end else if (st.full) begin
					cmd.op   = DP_SET_STAT;
					cmd.stat = ST_FULL;
					state_d  = S_DONE;
				end else begin
					cmd.op  = DP_INS_SETUP;
					state_d = S_UP0;
				end
			end
			S_UP0: begin
				if (st.at_root) begin
					cmd.op  = DP_FINAL_WR;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_UP_RD;
					state_d = S_UP1;
				end
			end
			S_UP1: begin
				cmd.op  = DP_UP_COST;
				state_d = S_UP2;
			end
			S_UP2: begin
				cmd.op  = DP_UP_MOVE;
				state_d = st.up_go ? S_UP0 : S_FIN;
			end
			S_FIN: begin
				cmd.op  = DP_FINAL_WR;
				state_d = S_DONE;
			end
			S_TOP1: begin
				cmd.op  = DP_TOP_COST;
				state_d = S_TOP2;
			end
			S_TOP2: begin
				cmd.op  = DP_TOP_SAVE;
				state_d = (st.mode == MODE_PEEK) ? S_DONE : S_REM0;
			end
			S_REM0: begin
				if (st.fill_one) begin
					cmd.op  = DP_DEC_FILL;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_LAST_RD;
					state_d = S_LAST1;
				end
			end
			S_LAST1: begin
				cmd.op  = DP_LAST_COST;
				state_d = S_LAST2;
			end
			S_LAST2: begin
				cmd.op  = DP_LAST_SAVE;
				state_d = S_DN0;
			end
			S_DEL1: begin
				if (st.last_is_id) begin
					cmd.op  = DP_DEC_FILL;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_LAST_COST;
					state_d = S_DEL2;
				end
			end
			S_DEL2: begin
				cmd.op  = DP_DEL_SETUP;
				state_d = st.del_down ? S_DN0 : S_UP0;
			end
			S_DN0: begin
				if (st.leaf) begin
					cmd.op  = DP_FINAL_WR;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_DN_RD;
					state_d = S_DN1;
				end
			end
			S_DN1: begin
				cmd.op  = DP_DN_COST;
				state_d = S_DN2;
			end
			S_DN2: begin
				cmd.op  = DP_DN_MOVE;
				state_d = st.dn_go ? S_DN0 : S_FIN;
			end
			S_DONE: begin
				if (emit) begin
					cmd.op  = DP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`IBHQ_ASSERT_NEXT(a_hold_result, state_q == S_DONE && out_valid_q && !m_ready, state_q == S_DONE, "result overwritten while stalled")
	`IBHQ_ASSERT_NEXT(a_init_once, state_q != S_INIT, state_q != S_INIT, "clearing pass restarted")
	`IBHQ_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result raised outside completion")

endmodule

// ===== rtl/ibhq_dp.sv =====
// Datapath of the heap queue: heap, slot, cost and seen memories with sift registers.
`include "indexed_binary_heap_queue_defines.svh"

module ibhq_dp import ibhq_pkg::*; #(
	parameter  int MAX_ELEMENTS = 1024,
	parameter  int COST_BITS    = 32,
	localparam int IW           = $clog2(MAX_ELEMENTS),
	localparam int SW           = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         in_mode,
	input  logic [9:0]         in_id,
	input  logic signed [31:0] in_cost,
	input  logic               cfg_we,
	input  logic               cfg_bit,
	input  dp_cmd_t            cmd,
	output dp_stat_t           st,
	output logic [9:0]         top_element,
	output logic [31:0]        top_cost,
	output logic [1:0]         status,
	output logic [10:0]        queued_count
);

	logic [IW-1:0]                heap_mem [MAX_ELEMENTS+1];
	logic [SW-1:0]                slot_mem [MAX_ELEMENTS];
	logic signed [COST_BITS-1:0]  cost_mem [MAX_ELEMENTS];
	logic                         seen_mem [MAX_ELEMENTS];

	logic [2:0]                   mode_q;
	logic [9:0]                   id_in_q;
	logic [IW-1:0]                elem_q;
	logic signed [COST_BITS-1:0]  cv_q;
	logic [SW-1:0]                fill_q;
	logic [SW-1:0]                i_q;
	logic [IW-1:0]                p_q;
	logic signed [COST_BITS-1:0]  c_q;
	logic [IW-1:0]                q_q;
	logic [IW-1:0]                hl_q, hr_q;
	logic                         rok_q;
	logic [SW-1:0]                slot_q;
	logic                         cand_q;
	logic [IW-1:0]                top_e_q;
	logic signed [COST_BITS-1:0]  top_c_q;
	status_t                      st_q;
	logic                         maxf_q;
	logic [IW-1:0]                clr_q;
	logic [9:0]                   res_elem_q;
	logic [31:0]                  res_cost_q;
	logic [1:0]                   res_stat_q;
	logic [10:0]                  res_cnt_q;

	logic [IW-1:0]                h_rd0, h_rd1;
	logic signed [COST_BITS-1:0]  c_rd0, c_rd1;
	logic [SW-1:0]                p_rd;
	logic                         v_rd;

	logic [SW-1:0]                h_ra0, h_ra1;
	logic [IW-1:0]                c_ra1;
	logic [SW:0]                  l_w, r_w;
	logic                         rok_w;
	logic                         pick_r;
	logic [IW-1:0]                hj_w;
	logic signed [COST_BITS-1:0]  cj_w;
	logic [SW-1:0]                j_w;
	logic                         up_go, dn_go;

	logic                         h_we, p_we, c_we, v_we;
	logic [SW-1:0]                h_wa, p_wd;
	logic [IW-1:0]                h_wd, p_wa, v_wa;
	logic                         v_wd;

	// True when cost a is served strictly before cost b.
	function automatic logic better(input logic signed [COST_BITS-1:0] a,
	                                input logic signed [COST_BITS-1:0] b,
	                                input logic mf);
		return mf ? (a > b) : (a < b);
	endfunction

	assign l_w    = {i_q, 1'b0};
	assign r_w    = l_w + (SW+1)'(1);
	assign rok_w  = r_w <= {1'b0, fill_q};
	assign pick_r = rok_q && better(c_rd1, c_rd0, maxf_q);
	assign hj_w   = pick_r ? hr_q : hl_q;
	assign cj_w   = pick_r ? c_rd1 : c_rd0;
	assign j_w    = pick_r ? r_w[SW-1:0] : l_w[SW-1:0];
	assign up_go  = better(c_q, c_rd0, maxf_q);
	assign dn_go  = better(cj_w, c_q, maxf_q);

	always_comb begin
		case (cmd.op)
			DP_CHK_H:   h_ra0 = p_rd;
			DP_UP_RD:   h_ra0 = i_q >> 1;
			DP_TOP_RD:  h_ra0 = SW'(1);
			DP_LAST_RD: h_ra0 = fill_q;
			DP_DN_RD:   h_ra0 = l_w[SW-1:0];
			default:    h_ra0 = '0;
		endcase
	end

	// The right child is fetched only when it lies inside the heap.
	assign h_ra1 = rok_w ? r_w[SW-1:0] : l_w[SW-1:0];
	assign c_ra1 = (cmd.op == DP_DN_COST) ? h_rd1 : elem_q;

	always_comb begin
		h_we = 1'b0;
		h_wa = i_q;
		h_wd = p_q;
		case (cmd.op)
			DP_FINAL_WR: h_we = 1'b1;
			DP_UP_MOVE: begin
				h_we = up_go;
				h_wd = q_q;
			end
			DP_DN_MOVE: begin
				h_we = dn_go;
				h_wd = hj_w;
			end
			default: h_we = 1'b0;
		endcase
		p_we = h_we;
		p_wa = h_wd;
		p_wd = h_wa;
	end

	assign c_we = (cmd.op == DP_INS_SETUP) || (cmd.op == DP_UPD_SETUP);
	assign v_we = (cmd.op == DP_INS_SETUP) || (cmd.op == DP_CLR_STEP);
	assign v_wa = (cmd.op == DP_CLR_STEP) ? clr_q : elem_q;
	assign v_wd = (cmd.op == DP_INS_SETUP);

	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_wa] <= h_wd;
		h_rd0 <= heap_mem[h_ra0];
		h_rd1 <= heap_mem[h_ra1];
	end

	always_ff @(posedge clk) begin
		if (p_we) slot_mem[p_wa] <= p_wd;
		p_rd <= slot_mem[elem_q];
	end

	always_ff @(posedge clk) begin
		if (c_we) cost_mem[elem_q] <= cv_q;
		c_rd0 <= cost_mem[h_rd0];
		c_rd1 <= cost_mem[c_ra1];
	end

	always_ff @(posedge clk) begin
		if (v_we) seen_mem[v_wa] <= v_wd;
		v_rd <= seen_mem[elem_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			maxf_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (cfg_we) maxf_q <= cfg_bit;
			case (cmd.op)
				DP_CLR_STEP:  clr_q  <= clr_q + IW'(1);
				DP_INS_SETUP: fill_q <= fill_q + SW'(1);
				DP_LAST_SAVE: fill_q <= fill_q - SW'(1);
				DP_DEL_SETUP: fill_q <= fill_q - SW'(1);
				DP_DEC_FILL:  fill_q <= fill_q - SW'(1);
				DP_ZERO_FILL: fill_q <= '0;
				default:      fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				mode_q  <= in_mode;
				id_in_q <= in_id;
				elem_q  <= IW'(in_id);
				cv_q    <= COST_BITS'(in_cost);
				top_e_q <= '0;
				top_c_q <= '0;
				st_q    <= ST_OK;
			end
			DP_SET_STAT: st_q <= cmd.stat;
			DP_CHK_H: begin
				slot_q <= p_rd;
				cand_q <= v_rd && (p_rd != '0) && (p_rd <= fill_q);
			end
			DP_INS_SETUP: begin
				i_q <= fill_q + SW'(1);
				p_q <= elem_q;
				c_q <= cv_q;
			end
			DP_UPD_SETUP: begin
				i_q <= slot_q;
				p_q <= elem_q;
				c_q <= cv_q;
			end
			DP_UP_COST: q_q <= h_rd0;
			DP_UP_MOVE: begin
				if (up_go) i_q <= i_q >> 1;
			end
			DP_TOP_COST:  top_e_q <= h_rd0;
			DP_TOP_SAVE:  top_c_q <= c_rd0;
			DP_LAST_COST: p_q <= h_rd0;
			DP_LAST_SAVE: begin
				c_q <= c_rd0;
				i_q <= SW'(1);
			end
			DP_DEL_SETUP: begin
				c_q <= c_rd0;
				i_q <= slot_q;
			end
			DP_DN_COST: begin
				hl_q  <= h_rd0;
				hr_q  <= h_rd1;
				rok_q <= rok_w;
			end
			DP_DN_MOVE: begin
				if (dn_go) i_q <= j_w;
			end
			DP_EMIT: begin
				res_elem_q <= 10'(top_e_q);
				res_cost_q <= 32'(top_c_q);
				res_stat_q <= st_q;
				res_cnt_q  <= 11'(fill_q);
			end
			default: cand_q <= cand_q;
		endcase
	end

	assign st.mode       = mode_t'(mode_q);
	assign st.id_bad     = 32'(id_in_q) >= 32'(MAX_ELEMENTS);
	assign st.queued     = cand_q && (h_rd0 == elem_q);
	assign st.full       = fill_q == SW'(MAX_ELEMENTS);
	assign st.empty      = fill_q == '0;
	assign st.fill_one   = fill_q == SW'(1);
	assign st.last_is_id = h_rd0 == elem_q;
	assign st.at_root    = i_q <= SW'(1);
	assign st.leaf       = l_w > {1'b0, fill_q};
	assign st.up_go      = up_go;
	assign st.dn_go      = dn_go;
	assign st.del_down   = better(c_rd1, c_rd0, maxf_q);
	assign st.clr_last   = clr_q == IW'(MAX_ELEMENTS - 1);

	assign top_element  = res_elem_q;
	assign top_cost     = res_cost_q;
	assign status       = res_stat_q;
	assign queued_count = res_cnt_q;

	`IBHQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= SW'(MAX_ELEMENTS), "heap fill beyond capacity")
	`IBHQ_ASSERT_NEXT(a_ins_grows, cmd.op == DP_INS_SETUP, fill_q == $past(fill_q) + SW'(1), "insert did not grow the heap")

endmodule
